// ===== hdl/hcbd_pkg.sv =====
// shared types, constants and helpers for the chunked body decoder
package hcbd_pkg;

    localparam int LENGTH_BITS_DEF = 32;

    localparam logic [7:0] CHAR_CR = 8'h0d;
    localparam logic [7:0] CHAR_LF = 8'h0a;

    typedef enum logic [2:0] {
        PH_SIZE  = 3'd0,
        PH_DATA  = 3'd1,
        PH_SKIP1 = 3'd2,
        PH_SKIP2 = 3'd3,
        PH_FIN1  = 3'd4,
        PH_FIN2  = 3'd5,
        PH_DONE  = 3'd6,
        PH_ERR   = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        CLS_FRAME = 3'd0,
        CLS_BODY  = 3'd1,
        CLS_FINAL = 3'd2,
        CLS_AFTER = 3'd3,
        CLS_ERROR = 3'd4
    } class_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] b);
        hex_t h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            h.val = 4'(b - 8'h30);
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            h.val = 4'(b - 8'h57);
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            h.val = 4'(b - 8'h37);
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

// ===== hdl/hcbd_core.sv =====
// decoder state machine: chunk phase, length counter and size line flags
module hcbd_core
    import hcbd_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       restart,
    output class_t     byte_class
);

    phase_t                   phase_reg, phase_next, phase_cur;
    logic [LENGTH_BITS-1:0]   bytes_left_reg, bytes_left_next, bytes_left_cur, bytes_left_dec;
    logic                     saw_cr_reg, saw_cr_next, saw_cr_cur;
    logic                     seen_nonhex_reg, seen_nonhex_next, seen_nonhex_cur;
    hex_t                     hx;
    logic                     overflow;

    // restart applies before this word is decoded
    assign phase_cur       = restart ? PH_SIZE : phase_reg;
    assign bytes_left_cur  = restart ? '0 : bytes_left_reg;
    assign saw_cr_cur      = restart ? 1'b0 : saw_cr_reg;
    assign seen_nonhex_cur = restart ? 1'b0 : seen_nonhex_reg;

    assign hx             = hex_decode(data_byte);
    assign overflow       = bytes_left_cur[LENGTH_BITS-1 -: 4] != 4'd0;
    assign bytes_left_dec = (bytes_left_cur != '0) ? bytes_left_cur - 1'b1 : bytes_left_cur;

    // next state
    always_comb
    begin
        phase_next       = phase_cur;
        bytes_left_next  = bytes_left_cur;
        saw_cr_next      = saw_cr_cur;
        seen_nonhex_next = seen_nonhex_cur;
        case (phase_cur)
            PH_SIZE:
            begin
                if (data_byte == CHAR_LF && saw_cr_cur)
                begin
                    saw_cr_next      = 1'b0;
                    seen_nonhex_next = 1'b0;
                    phase_next       = (bytes_left_cur == '0) ? PH_FIN1 : PH_DATA;
                end
                else
                begin
                    saw_cr_next = (data_byte == CHAR_CR);
                    if (!seen_nonhex_cur && hx.ok)
                    begin
                        if (overflow)
                        begin
                            phase_next = PH_ERR;
                        end
                        else
                        begin
                            bytes_left_next = {bytes_left_cur[LENGTH_BITS-5:0], hx.val};
                        end
                    end
                    else
                    begin
                        seen_nonhex_next = 1'b1;
                    end
                end
            end
            PH_DATA:
            begin
                bytes_left_next = bytes_left_dec;
                if (bytes_left_dec == '0)
                begin
                    phase_next = PH_SKIP1;
                end
            end
            PH_SKIP1:
            begin
                phase_next = PH_SKIP2;
            end
            PH_SKIP2:
            begin
                phase_next       = PH_SIZE;
                bytes_left_next  = '0;
                saw_cr_next      = 1'b0;
                seen_nonhex_next = 1'b0;
            end
            PH_FIN1:
            begin
                phase_next = PH_FIN2;
            end
            PH_FIN2:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = phase_cur;
            end
        endcase
    end

    // word class
    always_comb
    begin
        case (phase_cur)
            PH_SIZE:
            begin
                byte_class = (!(data_byte == CHAR_LF && saw_cr_cur) && !seen_nonhex_cur
                              && hx.ok && overflow) ? CLS_ERROR : CLS_FRAME;
            end
            PH_DATA:  byte_class = CLS_BODY;
            PH_SKIP1: byte_class = CLS_FRAME;
            PH_SKIP2: byte_class = CLS_FRAME;
            PH_FIN1:  byte_class = CLS_FRAME;
            PH_FIN2:  byte_class = CLS_FINAL;
            PH_DONE:  byte_class = CLS_AFTER;
            default:  byte_class = CLS_ERROR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_SIZE;
            bytes_left_reg  <= '0;
            saw_cr_reg      <= 1'b0;
            seen_nonhex_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            bytes_left_reg  <= bytes_left_next;
            saw_cr_reg      <= saw_cr_next;
            seen_nonhex_reg <= seen_nonhex_next;
        end
    end

endmodule

// ===== hdl/http_chunked_body_decoder_unit.sv =====
// HTTP/1.1 chunked body decoder: one byte in, one classified byte out per cycle while
// neither side stalls. Takes one word per clock while in_stall is low and returns one
// result word per input word. A word taken sits in the input register, is decoded and
// lands in the result register when that is empty or its result is taken. Throughput
// is one word per unstalled cycle, set by the per-word chunk state update in hcbd_core.
// While a result waits on out_stall the input register still takes one more word,
// then in_stall stays high until the result is taken. The chunk length is LENGTH_BITS
// wide; a size line whose digits overflow it gives class 4 (error) until restart.
// Classes: 0 framing, 1 body, 2 final framing byte, 3 after end of body, 4 error.
module http_chunked_body_decoder_unit
    import hcbd_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       restart,
    input  logic       segment_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] byte_class,
    output logic [7:0] body_byte,
    output logic       segment_end_echo
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_restart_reg;
    logic       in_last_reg;

    logic       out_valid_reg;
    logic [2:0] out_class_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;

    logic       advance;
    logic       take;
    class_t     cls;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign take     = in_valid && !in_stall;

    hcbd_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .data_byte  (in_byte_reg),
        .restart    (in_restart_reg),
        .byte_class (cls)
    );

    // input word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_byte_reg    <= data_byte;
            in_restart_reg <= restart;
            in_last_reg    <= segment_last;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_class_reg <= cls;
            out_byte_reg  <= in_byte_reg;
            out_last_reg  <= in_last_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign byte_class       = out_class_reg;
    assign body_byte        = out_byte_reg;
    assign segment_end_echo = out_last_reg;

    a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_class <= 3'(CLS_ERROR)))
        else $error("result class out of range");

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("pending input word lost");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !in_valid_reg) |=> !out_valid_reg)
        else $error("result delivered twice");

endmodule

// ===== tb/sv/http_chunked_body_decoder_unit_tb.sv =====
// testbench for the chunked body decoder: queued byte stream, predicted classes, word checks
`timescale 1ns / 1ps

module http_chunked_body_decoder_unit_tb;
    import hcbd_pkg::*;

    localparam int LEN_BITS    = LENGTH_BITS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 8;

    typedef struct {
        logic [7:0] data;
        logic       restart;
        logic       seg;
    } raw_word_t;

    typedef struct {
        class_t     cls;
        logic [7:0] data;
        logic       seg;
    } decoded_t;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_stall;
    logic [7:0] data_byte    = 8'h00;
    logic       restart      = 1'b0;
    logic       segment_last = 1'b0;
    logic       out_valid;
    logic       out_stall    = 1'b0;
    logic [2:0] byte_class;
    logic [7:0] body_byte;
    logic       segment_end_echo;

    http_chunked_body_decoder_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .data_byte        (data_byte),
        .restart          (restart),
        .segment_last     (segment_last),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .byte_class       (byte_class),
        .body_byte        (body_byte),
        .segment_end_echo (segment_end_echo)
    );

    // decoder state mirror
    phase_t              dec_phase  = PH_SIZE;
    logic [LEN_BITS-1:0] dec_left   = '0;
    logic [3:0]          dec_digits = 4'd0;
    logic                dec_cr     = 1'b0;
    logic                dec_nonhex = 1'b0;

    raw_word_t pending_bytes[$];
    decoded_t  expected_words[$];
    raw_word_t sent_word;
    decoded_t  want_word;
    decoded_t  check_word;

    logic restart_next = 1'b0;
    logic no_idle      = 1'b0;
    int   queued       = 0;
    int   bodies       = 0;
    int   cycle_cnt    = 0;
    int   mismatches   = 0;
    int   words_seen   = 0;
    int   body_seen    = 0;
    int   final_seen   = 0;
    int   after_seen   = 0;
    int   error_seen   = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic class_t decode_step(input logic [7:0] b, input logic rs);
        class_t     cls;
        logic       is_hex;
        logic [3:0] nib;
        is_hex = 1'b1;
        nib    = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
            nib = b[3:0];
        else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
            nib = b[3:0] + 4'd9;
        else
            is_hex = 1'b0;
        if (rs)
        begin
            dec_phase  = PH_SIZE;
            dec_left   = '0;
            dec_digits = 4'd0;
            dec_cr     = 1'b0;
            dec_nonhex = 1'b0;
        end
        cls = CLS_FRAME;
        case (dec_phase)
            PH_SIZE:
            begin
                if (b == CHAR_LF && dec_cr)
                begin
                    dec_digits = 4'd0;
                    dec_cr     = 1'b0;
                    dec_nonhex = 1'b0;
                    dec_phase  = (dec_left == '0) ? PH_FIN1 : PH_DATA;
                end
                else
                begin
                    dec_cr = (b == CHAR_CR);
                    if (!dec_nonhex && is_hex)
                    begin
                        if (dec_left[LEN_BITS-1 -: 4] != 4'd0)
                        begin
                            dec_phase = PH_ERR;
                            cls       = CLS_ERROR;
                        end
                        else
                        begin
                            dec_left = {dec_left[LEN_BITS-5:0], nib};
                            if (dec_digits < 4'd15)
                                dec_digits = dec_digits + 4'd1;
                        end
                    end
                    else
                    begin
                        dec_nonhex = 1'b1;
                    end
                end
            end
            PH_DATA:
            begin
                cls = CLS_BODY;
                if (dec_left != '0)
                    dec_left = dec_left - 1'b1;
                if (dec_left == '0)
                    dec_phase = PH_SKIP1;
            end
            PH_SKIP1:
            begin
                dec_phase = PH_SKIP2;
            end
            PH_SKIP2:
            begin
                dec_phase  = PH_SIZE;
                dec_left   = '0;
                dec_digits = 4'd0;
                dec_cr     = 1'b0;
                dec_nonhex = 1'b0;
            end
            PH_FIN1:
            begin
                dec_phase = PH_FIN2;
            end
            PH_FIN2:
            begin
                cls       = CLS_FINAL;
                dec_phase = PH_DONE;
            end
            PH_DONE:
            begin
                cls = CLS_AFTER;
            end
            default:
            begin
                cls = CLS_ERROR;
            end
        endcase
        return cls;
    endfunction

    task automatic queue_byte(input logic [7:0] b);
        raw_word_t w;
        w.data        = b;
        w.restart     = restart_next;
        w.seg         = 1'($urandom_range(1));
        restart_next  = 1'b0;
        pending_bytes = {pending_bytes, w};
        queued++;
    endtask

    task automatic queue_crlf_or_junk();
        if ($urandom_range(4) == 0)
        begin
            queue_byte(8'($urandom_range(255)));
            queue_byte(8'($urandom_range(255)));
        end
        else
        begin
            queue_byte(CHAR_CR);
            queue_byte(CHAR_LF);
        end
    endtask

    task automatic queue_size_line(input logic [63:0] len);
        int         nd;
        int         lead;
        int         k;
        logic [3:0] nib;
        logic [7:0] c;
        nd = 1;
        while (nd < 16 && (len >> (4 * nd)) != 0)
            nd++;
        lead = ($urandom_range(9) == 0) ? $urandom_range(16) : $urandom_range(1);
        if (len == 0 && $urandom_range(3) == 0)
        begin
            nd   = 0;
            lead = 0;
        end
        repeat (lead) queue_byte(8'h30);
        for (k = nd - 1; k >= 0; k--)
        begin
            nib = len[4*k +: 4];
            if (nib < 4'd10)
                c = 8'h30 + {4'h0, nib};
            else
                c = ($urandom_range(1) ? 8'h61 : 8'h41) + {4'h0, nib} - 8'd10;
            queue_byte(c);
        end
        if ($urandom_range(3) == 0)
        begin
            queue_byte(8'h3b);
            repeat ($urandom_range(4))
            begin
                c = 8'($urandom_range(255));
                if (c == CHAR_CR || c == CHAR_LF)
                    c = 8'h3d;
                queue_byte(c);
            end
        end
        if ($urandom_range(4) == 0)
        begin
            queue_byte(CHAR_CR);
            queue_byte(8'h20);
        end
        queue_byte(CHAR_CR);
        queue_byte(CHAR_LF);
    endtask

    task automatic queue_body();
        int          nchunks;
        int          len;
        int          pick;
        logic [63:0] big;
        bodies++;
        pick = $urandom_range(19);
        if (pick < 2)
        begin
            // raw noise with scattered restarts
            repeat ($urandom_range(8, 1))
            begin
                restart_next = ($urandom_range(3) == 0);
                queue_byte(8'($urandom_range(255)));
            end
            return;
        end
        restart_next = ($urandom_range(9) != 0);
        if (pick == 2)
        begin
            // huge but legal length, cut short by the next restart
            queue_size_line({32'h0, 32'hffff_ffff ^ 32'($urandom_range(255))});
            repeat ($urandom_range(5, 1)) queue_byte(8'($urandom_range(255)));
            restart_next = 1'b1;
            return;
        end
        nchunks = $urandom_range(3);
        repeat (nchunks)
        begin
            len = ($urandom_range(7) == 0) ? $urandom_range(64, 25) : $urandom_range(24, 1);
            queue_size_line(64'(len));
            repeat (len) queue_byte(8'($urandom_range(255)));
            queue_crlf_or_junk();
        end
        if (pick == 3)
        begin
            // length too wide for the counter
            big = {$urandom, $urandom};
            if (big[63:32] == 32'h0)
                big[35:32] = 4'(1 + $urandom_range(14));
            queue_size_line(big);
            repeat ($urandom_range(3)) queue_byte(8'($urandom_range(255)));
            return;
        end
        queue_size_line(64'h0);
        queue_crlf_or_junk();
        repeat ($urandom_range(2)) queue_byte(8'($urandom_range(255)));
    endtask

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_cnt, expected_words.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                sent_word      = pending_bytes.pop_front();
                want_word.cls  = decode_step(sent_word.data, sent_word.restart);
                want_word.data = sent_word.data;
                want_word.seg  = sent_word.seg;
                expected_words = {expected_words, want_word};
            end
            if (!(in_valid && in_stall))
            begin
                if (pending_bytes.size() != 0 && (no_idle || $urandom_range(99) >= 25))
                begin
                    in_valid     <= 1'b1;
                    data_byte    <= pending_bytes[0].data;
                    restart      <= pending_bytes[0].restart;
                    segment_last <= pending_bytes[0].seg;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                words_seen++;
                if (expected_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: class %0d byte %02h seg %0d",
                                 byte_class, body_byte, segment_end_echo);
                end
                else
                begin
                    check_word = expected_words.pop_front();
                    case (check_word.cls)
                        CLS_BODY:  body_seen++;
                        CLS_FINAL: final_seen++;
                        CLS_AFTER: after_seen++;
                        CLS_ERROR: error_seen++;
                        default:   ;
                    endcase
                    if (byte_class !== check_word.cls || body_byte !== check_word.data ||
                        segment_end_echo !== check_word.seg)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch at word %0d: expected class %0d byte %02h",
                                      " seg %0d, got class %0d byte %02h seg %0d"},
                                     words_seen, check_word.cls, check_word.data,
                                     check_word.seg, byte_class, body_byte,
                                     segment_end_echo);
                    end
                end
            end
            out_stall <= !no_idle && ($urandom_range(99) < 25);
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // size line with extension and lone cr, data extremes, last chunk, after end
        restart_next = 1'b1;
        queue_byte(8'h32);
        queue_byte(8'h3b);
        queue_byte(CHAR_CR);
        queue_byte(8'h7a);
        queue_byte(CHAR_CR);
        queue_byte(CHAR_LF);
        queue_byte(8'h00);
        queue_byte(8'hff);
        queue_byte(CHAR_CR);
        queue_byte(CHAR_LF);
        queue_byte(8'h30);
        queue_byte(CHAR_CR);
        queue_byte(CHAR_LF);
        queue_byte(CHAR_CR);
        queue_byte(CHAR_LF);
        queue_byte(8'h41);
        // length overflow, restart from the done state
        restart_next = 1'b1;
        repeat (4)
        begin
            queue_byte(8'h46);
            queue_byte(8'h66);
        end
        queue_byte(8'h61);
        // empty size line
        restart_next = 1'b1;
        queue_byte(CHAR_CR);
        queue_byte(CHAR_LF);

        // sender holds off until everything has drained
        while (pending_bytes.size() != 0 || expected_words.size() != 0)
            @(negedge clk);

        while (queued < 300)
            queue_body();
        while (pending_bytes.size() != 0 || expected_words.size() != 0)
            @(negedge clk);

        while (queued < 570)
            queue_body();
        no_idle = 1'b1;
        while (pending_bytes.size() > 150)
            @(negedge clk);
        no_idle = 1'b0;

        while (pending_bytes.size() != 0 || expected_words.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("checked %0d words from %0d generated bodies and noise runs",
                 words_seen, bodies);
        $display("body %0d, final framing %0d, after end %0d, error %0d, mismatches %0d",
                 body_seen, final_seen, after_seen, error_seen, mismatches);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
